>>> hdl/record_ring_manager_macros.svh
// Assertion macros for the record ring manager.
`ifndef RECORD_RING_MANAGER_MACROS_SVH
`define RECORD_RING_MANAGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/rrm_pkg.sv
// Shared types and constants of the record ring manager.
package rrm_pkg;

  localparam int TOT_W  = 19;
  localparam int HDR_BYTES = 16;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_PEEK  = 2'd1;
  localparam logic [1:0] MODE_POP   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_NO_POP    = 3'd5
  } status_t;

  // Classified command word passed from front to back.
  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       wtype;
    logic [15:0]      wflags;
    logic [TOT_W-1:0] total;
  } cmd_t;

  // One header slot.
  typedef struct packed {
    logic [16:0] size;
    logic [31:0] seq;
    logic [15:0] flags;
    logic [7:0]  rtype;
  } slot_t;

endpackage

>>> hdl/rrm_front.sv
// Front end: accepts input words, computes aligned record size, queues commands.
module rrm_front
  import rrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_write_type,
  input  logic [15:0] in_write_flags,
  input  logic [16:0] in_fixed_bytes,
  input  logic [16:0] in_blob_bytes,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd
);

  cmd_t             fifo_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic [TOT_W-1:0] sum;
  cmd_t             cmd_in;
  logic             push, pop;

  // Header plus payload, rounded up to 16 bytes
  always_comb begin
    sum = TOT_W'(in_fixed_bytes) + TOT_W'(in_blob_bytes) + TOT_W'(HDR_BYTES + 15);
    cmd_in.mode   = in_mode;
    cmd_in.wtype  = in_write_type;
    cmd_in.wflags = in_write_flags;
    cmd_in.total  = {sum[TOT_W-1:4], 4'b0000};
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hdl/rrm_back.sv
// Back end: ring pointers, header slot memory, command execution, result register.
module rrm_back
  import rrm_pkg::*;
#(
  parameter int RING_BYTES_LOG2 = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_record_offset,
  output logic [16:0] out_record_bytes,
  output logic [7:0]  out_record_type,
  output logic [15:0] out_record_flags,
  output logic [31:0] out_sequence_res,
  output logic [16:0] out_pending_bytes,
  output logic [31:0] out_lost_bytes,
  output logic [31:0] out_lost_records
);

  localparam int POS_W  = RING_BYTES_LOG2 + 1;
  localparam int CW     = ((POS_W > TOT_W) ? POS_W : TOT_W) + 1;
  localparam int SLOT_W = RING_BYTES_LOG2 - 4;
  localparam int SLOTS  = 1 << SLOT_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WREC, S_PEVAL} state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [4:0]       cap_log2_r;
  logic [POS_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [31:0]      seq_r, seq_nxt, dbytes_r, dbytes_nxt, drecs_r, drecs_nxt;
  logic [16:0]      held_r, held_nxt;

  logic             ov_r, ov_nxt;
  status_t          st_r, st_nxt;
  logic [15:0]      off_r, off_nxt;
  logic [16:0]      bytes_r, bytes_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      flags_r, flags_nxt;
  logic [31:0]      rseq_r, rseq_nxt;
  logic [16:0]      pend_r, pend_nxt;

  slot_t             mem [SLOTS];
  slot_t             rd_data_r, wr_data;
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_idx, rd_idx;

  logic [4:0]       lg_c;
  logic [CW-1:0]    cap, used, free_b, offset, to_end, needed, total, roff, size_c;
  logic [POS_W-1:0] used_p, used_nxt;
  logic             pad, out_free, emit, rec_go, bad;

  // Ring geometry from the current pointers
  always_comb begin
    if (cap_log2_r < 5'd5) lg_c = 5'd5;
    else if (cap_log2_r > 5'(RING_BYTES_LOG2)) lg_c = 5'(RING_BYTES_LOG2);
    else lg_c = cap_log2_r;
    cap    = CW'(1) << lg_c;
    used_p = wp_r - rp_r;
    used   = CW'(used_p);
    free_b = (used >= cap) ? '0 : cap - used;
    offset = CW'(wp_r) & (cap - CW'(1));
    roff   = CW'(rp_r) & (cap - CW'(1));
    to_end = cap - offset;
    total  = CW'(cmd_r.total);
    pad    = to_end < total;
    needed = total + (pad ? to_end : '0);
    size_c = CW'(rd_data_r.size);
    bad    = (size_c < CW'(HDR_BYTES)) || (size_c > used) || (size_c > cap) ||
             (rd_data_r.size[3:0] != 4'd0);
  end

  assign out_free = !ov_r || out_ready;

  // Command sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    seq_nxt    = seq_r;
    dbytes_nxt = dbytes_r;
    drecs_nxt  = drecs_r;
    held_nxt   = held_r;
    q_ready    = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = offset[RING_BYTES_LOG2-1:4];
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_idx     = roff[RING_BYTES_LOG2-1:4];
    emit       = 1'b0;
    rec_go     = 1'b0;
    st_nxt     = ST_OK;
    off_nxt    = '0;
    bytes_nxt  = '0;
    type_nxt   = '0;
    flags_nxt  = '0;
    rseq_nxt   = '0;

    unique case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt   = q_cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r.mode)
          MODE_WRITE: begin
            if (total > cap) begin
              emit   = out_free;
              st_nxt = ST_TOO_LARGE;
            end else if (free_b < needed) begin
              emit      = out_free;
              st_nxt    = ST_DROPPED;
              bytes_nxt = 17'(total);
              if (out_free) begin
                dbytes_nxt = dbytes_r + 32'(total);
                drecs_nxt  = drecs_r + 32'd1;
              end
            end else if (pad) begin
              // padding header fills the tail of the ring
              wr_en        = 1'b1;
              wr_data.size = 17'(to_end);
              wp_nxt       = wp_r + POS_W'(to_end);
              state_nxt    = S_WREC;
            end else begin
              rec_go = 1'b1;
            end
          end
          MODE_PEEK: begin
            if (used < CW'(HDR_BYTES)) begin
              emit   = out_free;
              st_nxt = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_PEVAL;
            end
          end
          MODE_POP: begin
            emit = out_free;
            if (held_r == '0) begin
              st_nxt = ST_NO_POP;
            end else begin
              off_nxt   = 16'(roff);
              bytes_nxt = held_r;
              if (out_free) begin
                rp_nxt   = rp_r + POS_W'(held_r);
                held_nxt = '0;
              end
            end
          end
          default: begin
            emit   = out_free;
            st_nxt = ST_NO_POP;
          end
        endcase
      end
      S_WREC: begin
        rec_go = 1'b1;
      end
      S_PEVAL: begin
        if (bad) begin
          emit   = out_free;
          st_nxt = ST_CORRUPT;
          if (out_free) begin
            rp_nxt   = wp_r;
            held_nxt = '0;
          end
        end else if (rd_data_r.rtype == 8'd0) begin
          // skip padding and look again
          rp_nxt    = rp_r + POS_W'(rd_data_r.size);
          state_nxt = S_EXEC;
        end else begin
          emit      = out_free;
          off_nxt   = 16'(roff);
          bytes_nxt = rd_data_r.size;
          type_nxt  = rd_data_r.rtype;
          flags_nxt = rd_data_r.flags;
          rseq_nxt  = rd_data_r.seq;
          if (out_free) held_nxt = rd_data_r.size;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Record header write, once the result slot is free
    if (rec_go && out_free) begin
      emit          = 1'b1;
      wr_en         = 1'b1;
      seq_nxt       = seq_r + 32'd1;
      wr_data.size  = 17'(total);
      wr_data.seq   = seq_r + 32'd1;
      wr_data.flags = cmd_r.wflags;
      wr_data.rtype = cmd_r.wtype;
      wp_nxt        = wp_r + POS_W'(total);
      off_nxt       = 16'(offset);
      bytes_nxt     = 17'(total);
      type_nxt      = cmd_r.wtype;
      flags_nxt     = cmd_r.wflags;
      rseq_nxt      = seq_r + 32'd1;
    end

    used_nxt = wp_nxt - rp_nxt;
    pend_nxt = 17'(used_nxt);
    if (emit) begin
      state_nxt = S_IDLE;
      ov_nxt    = 1'b1;
    end else begin
      ov_nxt = ov_r && !out_ready;
    end
  end

  // Header slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cap_log2_r <= 5'd16;
      wp_r       <= '0;
      rp_r       <= '0;
      seq_r      <= '0;
      dbytes_r   <= '0;
      drecs_r    <= '0;
      held_r     <= '0;
      ov_r       <= 1'b0;
    end else if (cfg_wr_en) begin
      state_r    <= S_IDLE;
      cap_log2_r <= cfg_wr_data;
      wp_r       <= '0;
      rp_r       <= '0;
      seq_r      <= '0;
      dbytes_r   <= '0;
      drecs_r    <= '0;
      held_r     <= '0;
      ov_r       <= ov_nxt;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      seq_r    <= seq_nxt;
      dbytes_r <= dbytes_nxt;
      drecs_r  <= drecs_nxt;
      held_r   <= held_nxt;
      ov_r     <= ov_nxt;
    end
    cmd_r <= cmd_nxt;
    if (emit) begin
      st_r    <= st_nxt;
      off_r   <= off_nxt;
      bytes_r <= bytes_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      rseq_r  <= rseq_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_record_offset = off_r;
  assign out_record_bytes  = bytes_r;
  assign out_record_type   = type_r;
  assign out_record_flags  = flags_r;
  assign out_sequence_res  = rseq_r;
  assign out_pending_bytes = pend_r;
  assign out_lost_bytes    = dbytes_r;
  assign out_lost_records  = drecs_r;

endmodule

>>> hdl/record_ring_manager.sv
// Top level of the record ring manager.
//
//  channel | direction | handshake            | content
//  in_*    | input     | in_valid / in_ready   | command word: write, peek or pop
//  out_*   | output    | out_valid / out_ready | one result word per command
//  cfg_*   | input     | cfg_wr_en             | capacity_log2, resets the ring
//
// A command is popped from the queue, then executed; a padded write first
// writes the padding header, and a peek first reads the header slot memory
// (a registered read), again per skipped padding record. Reset is synchronous,
// active low; the header memory is not cleared. A stalled result holds the back
// end; the front queue keeps taking up to two commands meanwhile.
`include "record_ring_manager_macros.svh"
module record_ring_manager
  import rrm_pkg::*;
#(
  parameter int RING_BYTES_LOG2 = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_write_type,
  input  logic [15:0] in_write_flags,
  input  logic [16:0] in_fixed_bytes,
  input  logic [16:0] in_blob_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_record_offset,
  output logic [16:0] out_record_bytes,
  output logic [7:0]  out_record_type,
  output logic [15:0] out_record_flags,
  output logic [31:0] out_sequence_res,
  output logic [16:0] out_pending_bytes,
  output logic [31:0] out_lost_bytes,
  output logic [31:0] out_lost_records
);

  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic chk_empty, pend_small, chk_ok, size_ok, chk_big, big_clear;

  rrm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_write_type,
    .in_write_flags, .in_fixed_bytes, .in_blob_bytes,
    .q_valid, .q_ready, .q_cmd
  );

  rrm_back #(.RING_BYTES_LOG2(RING_BYTES_LOG2)) u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_status, .out_record_offset, .out_record_bytes,
    .out_record_type, .out_record_flags, .out_sequence_res, .out_pending_bytes,
    .out_lost_bytes, .out_lost_records
  );

  // Result consistency checks
  assign chk_empty  = out_valid && out_status == ST_EMPTY;
  assign pend_small = out_pending_bytes < 17'd16;
  assign chk_ok     = out_valid && out_status == ST_OK && out_record_bytes != 17'd0;
  assign size_ok    = out_record_bytes[3:0] == 4'd0 && out_record_bytes >= 17'd16;
  assign chk_big    = out_valid && out_status == ST_TOO_LARGE;
  assign big_clear  = out_record_bytes == 17'd0 && out_sequence_res == 32'd0;

  `RRM_ASSERT_IMP(a_empty_pending, clk, rst_n, chk_empty, pend_small, "empty with header pending")
  `RRM_ASSERT_IMP(a_ok_aligned, clk, rst_n, chk_ok, size_ok, "record size not aligned")
  `RRM_ASSERT_IMP(a_too_large, clk, rst_n, chk_big, big_clear, "oversize write reports a record")

endmodule
